@@ rtl/mdrw_pkg.sv @@
package mdrw_pkg;

    typedef enum logic [1:0] {
        ACT_BUS_WRITE  = 2'd0,
        ACT_BUS_READ   = 2'd1,
        ACT_DISK_CELL  = 2'd2,
        ACT_WRITE_TICK = 2'd3
    } action_t;

    localparam logic [2:0] REG_CTRL_WRITE = 3'd0;
    localparam logic [2:0] REG_CTRL_READ  = 3'd1;
    localparam logic [2:0] REG_DATA       = 3'd2;
    localparam logic [2:0] REG_SYNC_CLOCK = 3'd3;
    localparam logic [2:0] REG_SYNC_DATA  = 3'd4;
    localparam logic [2:0] REG_SPARE      = 3'd5;

    // control_write bits
    localparam int CW_GATE = 0;
    localparam int CW_DATA = 1;
    localparam int CW_MARK = 2;
    localparam int CW_CRC  = 3;
    // control_read bits
    localparam int CR_CHECK = 3;
    localparam int CR_READ  = 4;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [7:0]  RDATA_UNUSED = 8'hFF;

    typedef struct packed {
        action_t    action;
        logic [2:0] reg_offset;
        logic [7:0] bus_wdata;
        logic       cell_bit;
        logic       index_in;
    } item_t;

    typedef struct packed {
        logic [7:0] bus_rdata;
        logic       write_cell;
        logic       write_cell_valid;
    } result_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            if (c[15] ^ data[i])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/mfm_disk_read_write_engine.sv @@
// channel | dir | handshake            | payload
// item    | in  | item_valid/item_stall | mdrw_pkg::item_t   (action, offset, wdata, cell, index)
// result  | out | result_valid/result_stall | mdrw_pkg::result_t (rdata, write cell, cell valid)
//
// every item gives exactly one result beat, one item per clock sustained while result_stall is low
// an item goes through the item register, then the state update into the result register
// the critical path is the 8-step crc-ccitt network feeding the state registers
// reset: item and result registers empty, core state cleared, crc seeded to 0xffff, crc check marked done
// a stalled result holds; the item register still takes one more beat, then item_stall rises
module mfm_disk_read_write_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mdrw_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mdrw_pkg::result_t result
);

    mdrw_pkg::item_t   item_reg;
    logic              item_full_reg, item_full_next;
    mdrw_pkg::result_t result_reg;
    logic              result_full_reg, result_full_next;
    mdrw_pkg::result_t core_result;
    logic              advance;
    logic              accept;

    assign advance          = item_full_reg && (!result_full_reg || !result_stall);
    assign item_stall       = item_full_reg && !advance;
    assign accept           = item_valid && !item_stall;
    assign item_full_next   = accept || (item_full_reg && !advance);
    assign result_full_next = advance || (result_full_reg && result_stall);

    mdrw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg   <= 1'b0;
            result_full_reg <= 1'b0;
        end
        else
        begin
            item_full_reg   <= item_full_next;
            result_full_reg <= result_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (advance)
            result_reg <= core_result;
    end

    assign result_valid = result_full_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_full_reg && !advance |=> item_full_reg && $stable(item_reg))
        else $error("waiting item lost or changed");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_full_reg)
        else $error("processed beat did not reach the result register");

    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.action != mdrw_pkg::ACT_WRITE_TICK
        |=> !result_reg.write_cell && !result_reg.write_cell_valid)
        else $error("write cell fields set outside a write tick");

    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.action != mdrw_pkg::ACT_BUS_READ |=> result_reg.bus_rdata == 8'h00)
        else $error("read data set outside a bus read");
`endif

endmodule

@@ rtl/mdrw_core.sv @@
module mdrw_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mdrw_pkg::item_t   item,
    output mdrw_pkg::result_t result
);

    logic [5:0]  control_write_reg, control_write_next;
    logic [7:0]  control_read_reg, control_read_next;
    logic [7:0]  sync_clock_reg, sync_clock_next;
    logic [7:0]  sync_data_reg, sync_data_next;
    logic [7:0]  spare_reg, spare_next;
    logic        writing_on_reg, writing_on_next;
    logic        reading_on_reg, reading_on_next;
    logic        sync_found_reg, sync_found_next;
    logic [15:0] cell_shift_reg, cell_shift_next;
    logic [4:0]  cell_count_reg, cell_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  read_byte_reg, read_byte_next;
    logic        read_ready_reg, read_ready_next;
    logic        read_was_sync_reg, read_was_sync_next;
    logic        crc_bad_reg, crc_bad_next;
    logic        crc_done_reg, crc_done_next;
    logic [7:0]  write_byte_reg, write_byte_next;
    logic        write_ready_reg, write_ready_next;
    logic        last_data_bit_reg, last_data_bit_next;

    logic [15:0] sync_word;
    logic [15:0] shifted;
    logic [7:0]  extracted;
    logic [7:0]  enc_byte;
    logic [15:0] enc_raw;
    logic [15:0] crc_base;
    logic [7:0]  crc_data;
    logic [15:0] crc_upd;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sync_word[2*i+1] = sync_clock_reg[i];
            sync_word[2*i]   = sync_data_reg[i];
        end
    end

    assign shifted = {cell_shift_reg[14:0], item.cell_bit};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            extracted[i] = shifted[2*i];
        end
    end

    // mfm encode of the next byte to write
    assign enc_byte = control_write_reg[mdrw_pkg::CW_DATA] ? write_byte_reg : crc_reg[15:8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            enc_raw[2*i]   = enc_byte[i];
            enc_raw[2*i+1] = !enc_byte[i] && !((i == 7) ? last_data_bit_reg : enc_byte[(i+1)%8]);
        end
        if (control_write_reg[mdrw_pkg::CW_DATA] && control_write_reg[mdrw_pkg::CW_MARK])
            enc_raw[{control_read_reg[2:0], 1'b1}] = 1'b0;
    end

    // one shared crc network: write path or read path
    always_comb
    begin
        if (item.action == mdrw_pkg::ACT_WRITE_TICK)
        begin
            crc_base = crc_reg;
            crc_data = write_byte_reg;
        end
        else if (sync_found_reg)
        begin
            crc_base = crc_reg;
            crc_data = extracted;
        end
        else
        begin
            crc_base = mdrw_pkg::CRC_SEED;
            crc_data = sync_data_reg;
        end
    end

    assign crc_upd = mdrw_pkg::crc_update(crc_base, crc_data);

    always_comb
    begin
        logic deliver;
        logic [4:0] cnt_inc;
        control_write_next = control_write_reg;
        control_read_next  = control_read_reg;
        sync_clock_next    = sync_clock_reg;
        sync_data_next     = sync_data_reg;
        spare_next         = spare_reg;
        writing_on_next    = writing_on_reg;
        reading_on_next    = reading_on_reg;
        sync_found_next    = sync_found_reg;
        cell_shift_next    = cell_shift_reg;
        cell_count_next    = cell_count_reg;
        crc_next           = crc_reg;
        read_byte_next     = read_byte_reg;
        read_ready_next    = read_ready_reg;
        read_was_sync_next = read_was_sync_reg;
        crc_bad_next       = crc_bad_reg;
        crc_done_next      = crc_done_reg;
        write_byte_next    = write_byte_reg;
        write_ready_next   = write_ready_reg;
        last_data_bit_next = last_data_bit_reg;
        result             = '0;
        deliver            = 1'b0;
        cnt_inc            = cell_count_reg + 5'd1;

        unique case (item.action)
            mdrw_pkg::ACT_BUS_WRITE:
            begin
                unique case (item.reg_offset)
                    mdrw_pkg::REG_CTRL_WRITE:
                    begin
                        control_write_next = item.bus_wdata[5:0];
                        if (!control_write_reg[mdrw_pkg::CW_CRC]
                            && item.bus_wdata[mdrw_pkg::CW_CRC])
                            crc_next = mdrw_pkg::CRC_SEED;
                        if (!control_write_reg[mdrw_pkg::CW_GATE]
                            && item.bus_wdata[mdrw_pkg::CW_GATE])
                        begin
                            writing_on_next    = 1'b1;
                            sync_found_next    = 1'b0;
                            cell_count_next    = '0;
                            last_data_bit_next = 1'b0;
                        end
                        else if (control_write_reg[mdrw_pkg::CW_GATE]
                                 && !item.bus_wdata[mdrw_pkg::CW_GATE])
                        begin
                            writing_on_next = 1'b0;
                            sync_found_next = 1'b0;
                            cell_shift_next = '0;
                            cell_count_next = '0;
                        end
                    end
                    mdrw_pkg::REG_CTRL_READ:
                    begin
                        control_read_next = item.bus_wdata;
                        if (!control_read_reg[mdrw_pkg::CR_READ]
                            && item.bus_wdata[mdrw_pkg::CR_READ])
                        begin
                            reading_on_next = 1'b1;
                            sync_found_next = 1'b0;
                            crc_bad_next    = 1'b0;
                            if (!writing_on_reg)
                            begin
                                cell_shift_next = '0;
                                cell_count_next = '0;
                            end
                        end
                        else if (!item.bus_wdata[mdrw_pkg::CR_READ])
                            reading_on_next = 1'b0;
                        if (!control_read_reg[mdrw_pkg::CR_CHECK]
                            && item.bus_wdata[mdrw_pkg::CR_CHECK])
                        begin
                            crc_bad_next  = 1'b0;
                            crc_done_next = 1'b0;
                        end
                    end
                    mdrw_pkg::REG_DATA:
                    begin
                        write_byte_next  = item.bus_wdata;
                        write_ready_next = 1'b0;
                    end
                    mdrw_pkg::REG_SYNC_CLOCK: sync_clock_next = item.bus_wdata;
                    mdrw_pkg::REG_SYNC_DATA:  sync_data_next  = item.bus_wdata;
                    mdrw_pkg::REG_SPARE:      spare_next      = item.bus_wdata;
                    default: ;
                endcase
            end
            mdrw_pkg::ACT_BUS_READ:
            begin
                unique case (item.reg_offset)
                    mdrw_pkg::REG_CTRL_WRITE:
                        result.bus_rdata = {write_ready_reg, !item.index_in, control_write_reg};
                    mdrw_pkg::REG_CTRL_READ:
                        result.bus_rdata = {read_ready_reg, read_was_sync_reg, crc_bad_reg,
                                            control_read_reg[4:0]};
                    mdrw_pkg::REG_DATA:
                    begin
                        result.bus_rdata = read_byte_reg;
                        read_ready_next  = 1'b0;
                    end
                    mdrw_pkg::REG_SYNC_CLOCK: result.bus_rdata = sync_clock_reg;
                    mdrw_pkg::REG_SYNC_DATA:  result.bus_rdata = sync_data_reg;
                    mdrw_pkg::REG_SPARE:      result.bus_rdata = spare_reg;
                    default:                  result.bus_rdata = mdrw_pkg::RDATA_UNUSED;
                endcase
            end
            mdrw_pkg::ACT_DISK_CELL:
            begin
                if (!writing_on_reg && reading_on_reg)
                begin
                    cell_shift_next = shifted;
                    if (!sync_found_reg)
                    begin
                        if (shifted == sync_word)
                        begin
                            sync_found_next    = 1'b1;
                            cell_count_next    = '0;
                            deliver            = 1'b1;
                            read_byte_next     = sync_data_reg;
                            read_was_sync_next = 1'b1;
                        end
                    end
                    else if (cnt_inc == 5'd16)
                    begin
                        cell_count_next    = '0;
                        deliver            = 1'b1;
                        read_byte_next     = extracted;
                        read_was_sync_next = (shifted == sync_word);
                    end
                    else
                        cell_count_next = cnt_inc;
                    if (deliver)
                    begin
                        // check compares the crc before this byte goes in
                        if (control_read_reg[mdrw_pkg::CR_CHECK] && !crc_done_reg)
                        begin
                            crc_bad_next  = (crc_base != 16'h0000);
                            crc_done_next = 1'b1;
                        end
                        crc_next        = crc_upd;
                        read_ready_next = 1'b1;
                    end
                end
            end
            mdrw_pkg::ACT_WRITE_TICK:
            begin
                if (writing_on_reg)
                begin
                    result.write_cell_valid = 1'b1;
                    if (cell_count_reg == 5'd0)
                    begin
                        if (control_write_reg[mdrw_pkg::CW_DATA])
                        begin
                            if (control_write_reg[mdrw_pkg::CW_CRC])
                                crc_next = crc_upd;
                        end
                        else
                            crc_next = {crc_reg[7:0], 8'h00};
                        write_ready_next   = 1'b1;
                        last_data_bit_next = enc_byte[0];
                        result.write_cell  = enc_raw[15];
                        cell_shift_next    = {enc_raw[14:0], 1'b0};
                        cell_count_next    = 5'd15;
                    end
                    else
                    begin
                        result.write_cell = cell_shift_reg[15];
                        cell_shift_next   = {cell_shift_reg[14:0], 1'b0};
                        cell_count_next   = cell_count_reg - 5'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_write_reg <= '0;
            control_read_reg  <= '0;
            sync_clock_reg    <= '0;
            sync_data_reg     <= '0;
            spare_reg         <= '0;
            writing_on_reg    <= 1'b0;
            reading_on_reg    <= 1'b0;
            sync_found_reg    <= 1'b0;
            cell_shift_reg    <= '0;
            cell_count_reg    <= '0;
            crc_reg           <= mdrw_pkg::CRC_SEED;
            read_byte_reg     <= '0;
            read_ready_reg    <= 1'b0;
            read_was_sync_reg <= 1'b0;
            crc_bad_reg       <= 1'b0;
            crc_done_reg      <= 1'b1;
            write_byte_reg    <= '0;
            write_ready_reg   <= 1'b0;
            last_data_bit_reg <= 1'b0;
        end
        else if (fire)
        begin
            control_write_reg <= control_write_next;
            control_read_reg  <= control_read_next;
            sync_clock_reg    <= sync_clock_next;
            sync_data_reg     <= sync_data_next;
            spare_reg         <= spare_next;
            writing_on_reg    <= writing_on_next;
            reading_on_reg    <= reading_on_next;
            sync_found_reg    <= sync_found_next;
            cell_shift_reg    <= cell_shift_next;
            cell_count_reg    <= cell_count_next;
            crc_reg           <= crc_next;
            read_byte_reg     <= read_byte_next;
            read_ready_reg    <= read_ready_next;
            read_was_sync_reg <= read_was_sync_next;
            crc_bad_reg       <= crc_bad_next;
            crc_done_reg      <= crc_done_next;
            write_byte_reg    <= write_byte_next;
            write_ready_reg   <= write_ready_next;
            last_data_bit_reg <= last_data_bit_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cell_count_reg <= 5'd16)
        else $error("cell count out of range");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(crc_reg) && $stable(cell_shift_reg) && $stable(cell_count_reg))
        else $error("state changed without an item");
`endif

endmodule
